/* sv/kmcd_pkg.sv */
// ----------------------------------------------------------------------------
// kmcd_pkg
// Shared types and constants for the key matrix change detector.
// ----------------------------------------------------------------------------
package kmcd_pkg;

   localparam int IDX_W      = 5;
   localparam int COL_W      = 8;
   localparam int MAP_W      = 8;
   localparam int KEY_W      = 10;
   localparam int SCAN_W     = 8;
   localparam int BYTE_SHIFT = 3;

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_MAP    = 1'b1
   } req_kind_type;

   typedef enum logic {
      EV_KEY  = 1'b0,
      EV_SYNC = 1'b1
   } evt_kind_type;

   typedef struct packed {
      evt_kind_type            kind;
      logic [SCAN_W-1:0]       scan_code;
      logic                    pressed;
      logic                    last;
   } evt_type;

endpackage

/* sv/kmcd_req_if.sv */
// ----------------------------------------------------------------------------
// kmcd_req_if
// Request channel: scan byte samples and keymap writes.
// ----------------------------------------------------------------------------
interface kmcd_req_if import kmcd_pkg::*;;
   logic                valid;
   logic                ready;
   logic                kind;
   logic [IDX_W-1:0]    byte_index;
   logic [COL_W-1:0]    column_bits;
   logic [MAP_W-1:0]    map_index;
   logic [KEY_W-1:0]    map_keycode;

   modport source (
      output valid, kind, byte_index, column_bits, map_index, map_keycode,
      input  ready
   );

   modport sink (
      input  valid, kind, byte_index, column_bits, map_index, map_keycode,
      output ready
   );
endinterface

/* sv/kmcd_rsp_if.sv */
// ----------------------------------------------------------------------------
// kmcd_rsp_if
// Response channel: key change and end-of-scan sync events.
// ----------------------------------------------------------------------------
interface kmcd_rsp_if import kmcd_pkg::*;;
   logic                valid;
   logic                ready;
   logic                event_kind;
   logic [SCAN_W-1:0]   scan_code;
   logic [KEY_W-1:0]    key_code;
   logic                pressed;
   logic                last_of_run;

   modport source (
      output valid, event_kind, scan_code, key_code, pressed, last_of_run,
      input  ready
   );

   modport sink (
      input  valid, event_kind, scan_code, key_code, pressed, last_of_run,
      output ready
   );
endinterface

/* sv/kmcd_ram.sv */
// ----------------------------------------------------------------------------
// kmcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kmcd_ram #(
   parameter int WIDTH  = 10,
   parameter int DEPTH  = 144,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

/* sv/kmcd_event_gen.sv */
// ----------------------------------------------------------------------------
// kmcd_event_gen
// Previous-scan store, change flag and work register issuing one event per
// cycle while advance is high, changed bits lowest first, then optional sync.
// ----------------------------------------------------------------------------
module kmcd_event_gen import kmcd_pkg::*; #(
   parameter int SCAN_BYTES = 18
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [IDX_W-1:0]  byte_index,
   input  logic [COL_W-1:0]  column_bits,
   input  logic              advance,
   output logic              ready,
   output logic              evt_valid,
   output evt_type           evt
);

   localparam int PW = (SCAN_BYTES > 1) ? $clog2(SCAN_BYTES) : 1;

   logic [COL_W-1:0] prev_ff [SCAN_BYTES];
   logic             change_seen_ff;
   logic             busy_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [COL_W-1:0] now_ff;
   logic [COL_W-1:0] mask_ff;
   logic             sync_ff;

   logic             in_range;
   logic             is_last_byte;
   logic [COL_W-1:0] prev_rd;
   logic [COL_W-1:0] diff;
   logic             sync_req;
   logic             load;
   logic [2:0]       bit_pos;
   logic [COL_W-1:0] mask_in;
   logic             fire;
   logic             done;

   assign in_range     = {1'b0, byte_index} < (IDX_W+1)'(SCAN_BYTES);
   assign is_last_byte = byte_index == IDX_W'(SCAN_BYTES - 1);
   assign prev_rd      = in_range ? prev_ff[byte_index[PW-1:0]] : '0;
   assign diff         = column_bits ^ prev_rd;
   assign sync_req     = is_last_byte && (change_seen_ff || (diff != '0));
   assign load         = take && in_range && ((diff != '0) || sync_req);

   // lowest changed bit
   always_comb begin
      bit_pos = '0;
      for (int i = COL_W - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            bit_pos = 3'(i);
         end
      end
   end

   assign mask_in = mask_ff & (mask_ff - COL_W'(1));

   always_comb begin
      evt = '0;
      if (mask_ff != '0) begin
         evt.kind      = EV_KEY;
         evt.scan_code = {idx_ff, bit_pos};
         evt.pressed   = ~now_ff[bit_pos];
         evt.last      = (mask_in == '0) && !sync_ff;
      end else begin
         evt.kind = EV_SYNC;
         evt.last = 1'b1;
      end
   end

   assign evt_valid = busy_ff;
   assign fire      = busy_ff && advance;
   assign done      = fire && evt.last;
   assign ready     = !busy_ff || done;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SCAN_BYTES; i++) begin
            prev_ff[i] <= '0;
         end
         change_seen_ff <= 1'b0;
      end else if (take && in_range) begin
         prev_ff[byte_index[PW-1:0]] <= column_bits;
         if (is_last_byte) begin
            change_seen_ff <= 1'b0;
         end else if (diff != '0) begin
            change_seen_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (load) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         idx_ff  <= byte_index;
         now_ff  <= column_bits;
         mask_ff <= diff;
         sync_ff <= sync_req;
      end else if (fire && (mask_ff != '0)) begin
         mask_ff <= mask_in;
      end
   end

   a_busy_has_work: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> ((mask_ff != '0) || sync_ff))
      else $error("work register busy with nothing to issue");

   a_sync_is_last: assert property (@(posedge clock) disable iff (reset)
      (evt_valid && (evt.kind == EV_SYNC)) |-> evt.last)
      else $error("sync event not marked last");

   a_load_when_ready: assert property (@(posedge clock) disable iff (reset)
      (fire && !evt.last) |=> busy_ff)
      else $error("work register emptied before last event");

endmodule

/* sv/key_matrix_change_detector.sv */
// ----------------------------------------------------------------------------
// key_matrix_change_detector
// Compares sampled matrix column bytes with the previous scan, emits one key
// event per changed bit with its keymap code, then a sync if the scan changed.
//
//   channel  direction  transfer carries
//   req      in         scan byte sample or keymap write
//   rsp      out        key change event or end-of-scan sync
//
// One result leaves the work register per cycle while rsp is not stalled;
// items causing none (keymap writes, unchanged bytes) never occupy it.
// The next item is taken in the cycle the last result of the current one
// moves to the output register, which results reach via the work register.
// Synchronous reset clears the previous-scan bytes, the change flag and the
// keymap valid bits; unwritten keymap entries read as zero.
// A stalled rsp holds the output register and, behind it, the work register.
// ----------------------------------------------------------------------------
module key_matrix_change_detector import kmcd_pkg::*; #(
   parameter int SCAN_BYTES     = 18,
   parameter int KEYMAP_ENTRIES = 144
) (
   input  logic         clock,
   input  logic         reset,
   kmcd_req_if.sink     req,
   kmcd_rsp_if.source   rsp
);

   localparam int AW = (KEYMAP_ENTRIES > 1) ? $clog2(KEYMAP_ENTRIES) : 1;

   logic              gen_ready;
   logic              evt_valid;
   evt_type           evt;
   logic              accept;
   logic              take;
   logic              map_wr;
   logic              advance;
   logic              load_out;
   logic              sc_in_range;
   logic [KEY_W-1:0]  ram_data;

   logic              key_ok_ff [KEYMAP_ENTRIES];
   logic              rsp_valid_ff;
   evt_kind_type      kind_ff;
   logic [SCAN_W-1:0] scan_ff;
   logic              pressed_ff;
   logic              last_ff;
   logic              hit_ff;

   assign req.ready = gen_ready;
   assign accept    = req.valid && gen_ready;
   assign take      = accept && (req_kind_type'(req.kind) == REQ_SAMPLE);
   assign map_wr    = accept && (req_kind_type'(req.kind) == REQ_MAP) &&
                      ({1'b0, req.map_index} < (MAP_W+1)'(KEYMAP_ENTRIES));
   assign advance   = !rsp_valid_ff || rsp.ready;
   assign load_out  = evt_valid && advance;
   assign sc_in_range = {1'b0, evt.scan_code} < (SCAN_W+1)'(KEYMAP_ENTRIES);

   kmcd_event_gen #(
      .SCAN_BYTES (SCAN_BYTES)
   ) u_event_gen (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .byte_index  (req.byte_index),
      .column_bits (req.column_bits),
      .advance     (advance),
      .ready       (gen_ready),
      .evt_valid   (evt_valid),
      .evt         (evt)
   );

   kmcd_ram #(
      .WIDTH (KEY_W),
      .DEPTH (KEYMAP_ENTRIES)
   ) u_keymap (
      .clock      (clock),
      .wr_en      (map_wr),
      .wr_addr    (req.map_index[AW-1:0]),
      .wr_data    (req.map_keycode),
      .rd_en      (load_out),
      .rd_addr    (evt.scan_code[AW-1:0]),
      .rd_data_ff (ram_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEYMAP_ENTRIES; i++) begin
            key_ok_ff[i] <= 1'b0;
         end
      end else if (map_wr) begin
         key_ok_ff[req.map_index[AW-1:0]] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= evt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         kind_ff    <= evt.kind;
         scan_ff    <= evt.scan_code;
         pressed_ff <= evt.pressed;
         last_ff    <= evt.last;
         hit_ff     <= (evt.kind == EV_KEY) && sc_in_range &&
                       key_ok_ff[evt.scan_code[AW-1:0]];
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.event_kind  = kind_ff;
   assign rsp.scan_code   = scan_ff;
   assign rsp.key_code    = hit_ff ? ram_data : '0;
   assign rsp.pressed     = pressed_ff;
   assign rsp.last_of_run = last_ff;

   a_hit_on_key_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && hit_ff) |-> (kind_ff == EV_KEY))
      else $error("keymap hit on a sync event");

   a_sync_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (kind_ff == EV_SYNC)) |-> ((scan_ff == '0) && !pressed_ff))
      else $error("sync event with key fields set");

endmodule

/* dv/key_matrix_change_detector_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_change_detector_tb
// Drives keymap writes and scan byte samples through the request channel and
// checks every key event and end-of-scan sync against expected events from an
// in-bench model of the matrix state or typed in a directed table. The table
// covers the corner cases, then random scan passes, noise bytes and keymap
// writes run with bursty requests and a stalling response side.
// ----------------------------------------------------------------------------
module key_matrix_change_detector_tb;
   import kmcd_pkg::*;

   localparam int SCAN_BYTES     = 18;
   localparam int KEYMAP_ENTRIES = 144;
   localparam int RANDOM_ITEMS   = 450;
   localparam int HOLDOFF_START  = 300;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 40;

   typedef enum logic [1:0] {
      YIELD_NONE,
      YIELD_ONE,
      YIELD_PREDICTED
   } yield_mode_type;

   typedef struct packed {
      req_kind_type        kind;
      logic [IDX_W-1:0]    byte_index;
      logic [COL_W-1:0]    column_bits;
      logic [MAP_W-1:0]    map_index;
      logic [KEY_W-1:0]    map_keycode;
   } scan_req_type;

   typedef struct packed {
      evt_kind_type        kind;
      logic [SCAN_W-1:0]   scan_code;
      logic [KEY_W-1:0]    key_code;
      logic                pressed;
      logic                last;
   } key_event_type;

   typedef struct packed {
      yield_mode_type      mode;
      scan_req_type        req;
      key_event_type       evt;
   } directed_row_type;

   localparam key_event_type NO_EVT = '0;

   localparam directed_row_type DIRECTED [24] = '{
      '{YIELD_NONE,      '{REQ_MAP,    5'd0,  8'h00, 8'd0,   10'd767},   NO_EVT},
      '{YIELD_NONE,      '{REQ_MAP,    5'd0,  8'h00, 8'd143, 10'h155},   NO_EVT},
      '{YIELD_NONE,      '{REQ_MAP,    5'd0,  8'h00, 8'd255, 10'h3FF},   NO_EVT},
      '{YIELD_NONE,      '{REQ_MAP,    5'd0,  8'h00, 8'd7,   10'h2AA},   NO_EVT},
      '{YIELD_ONE,       '{REQ_SAMPLE, 5'd0,  8'h01, 8'd0,   10'd0},
                         '{EV_KEY,  8'd0,   10'd767,  1'b0, 1'b1}},
      '{YIELD_NONE,      '{REQ_SAMPLE, 5'd0,  8'h01, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_PREDICTED, '{REQ_SAMPLE, 5'd0,  8'h7F, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_PREDICTED, '{REQ_SAMPLE, 5'd17, 8'h01, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_NONE,      '{REQ_SAMPLE, 5'd17, 8'h01, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_PREDICTED, '{REQ_SAMPLE, 5'd17, 8'h7F, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_PREDICTED, '{REQ_SAMPLE, 5'd17, 8'hFF, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_NONE,      '{REQ_SAMPLE, 5'd18, 8'h00, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_NONE,      '{REQ_SAMPLE, 5'd31, 8'hAA, 8'hFF,  10'h3FF},   NO_EVT},
      '{YIELD_PREDICTED, '{REQ_SAMPLE, 5'd5,  8'hFF, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_ONE,       '{REQ_SAMPLE, 5'd17, 8'hFF, 8'd0,   10'd0},
                         '{EV_SYNC, 8'd0,   10'd0,    1'b0, 1'b1}},
      '{YIELD_PREDICTED, '{REQ_SAMPLE, 5'd17, 8'h00, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_NONE,      '{REQ_MAP,    5'd0,  8'h00, 8'd128, 10'h3FF},   NO_EVT},
      '{YIELD_PREDICTED, '{REQ_SAMPLE, 5'd16, 8'hFF, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_ONE,       '{REQ_SAMPLE, 5'd16, 8'hFE, 8'd0,   10'd0},
                         '{EV_KEY,  8'd128, 10'h3FF,  1'b1, 1'b1}},
      '{YIELD_PREDICTED, '{REQ_SAMPLE, 5'd5,  8'h00, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_ONE,       '{REQ_SAMPLE, 5'd17, 8'h00, 8'd0,   10'd0},
                         '{EV_SYNC, 8'd0,   10'd0,    1'b0, 1'b1}},
      '{YIELD_NONE,      '{REQ_SAMPLE, 5'd17, 8'h00, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_NONE,      '{REQ_MAP,    5'd0,  8'h00, 8'd0,   10'd0},     NO_EVT},
      '{YIELD_PREDICTED, '{REQ_SAMPLE, 5'd0,  8'hFF, 8'd0,   10'd0},     NO_EVT}
   };

   logic clock = 1'b0;
   logic reset;

   kmcd_req_if req_if ();
   kmcd_rsp_if rsp_if ();

   key_matrix_change_detector uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   always #2 clock = ~clock;

   // matrix state as the block should hold it
   logic [COL_W-1:0]  prev_cols [SCAN_BYTES];
   logic [KEY_W-1:0]  keymap [KEYMAP_ENTRIES];
   logic              change_seen;
   key_event_type     fresh_events [$];
   key_event_type     pending_events [$];

   int mismatches = 0;
   int burst_left = 0;
   int items_sent = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic track_matrix(input scan_req_type r);
      logic [COL_W-1:0]  diff;
      logic [SCAN_W-1:0] code;
      key_event_type     ev;
      fresh_events.delete();
      if (r.kind == REQ_MAP) begin
         if (r.map_index < KEYMAP_ENTRIES) keymap[r.map_index] = r.map_keycode;
      end else if (r.byte_index < SCAN_BYTES) begin
         diff = r.column_bits ^ prev_cols[r.byte_index];
         for (int b = 0; b < COL_W; b++) begin
            if (diff[b]) begin
               code = (SCAN_W'(r.byte_index) << BYTE_SHIFT) + SCAN_W'(b);
               ev.kind = EV_KEY;
               ev.scan_code = code;
               ev.key_code = (code < KEYMAP_ENTRIES) ? keymap[code] : '0;
               ev.pressed = ~r.column_bits[b];
               ev.last = 1'b0;
               fresh_events.push_back(ev);
               change_seen = 1'b1;
            end
         end
         prev_cols[r.byte_index] = r.column_bits;
         if (r.byte_index == SCAN_BYTES - 1) begin
            if (change_seen) begin
               ev = '0;
               ev.kind = EV_SYNC;
               fresh_events.push_back(ev);
            end
            change_seen = 1'b0;
         end
         if (fresh_events.size() > 0) begin
            ev = fresh_events[fresh_events.size() - 1];
            ev.last = 1'b1;
            fresh_events[fresh_events.size() - 1] = ev;
         end
      end
   endtask

   function automatic bit is_effective(input scan_req_type r);
      return (r.kind == REQ_MAP) ? (r.map_index < KEYMAP_ENTRIES)
                                 : (r.byte_index < SCAN_BYTES);
   endfunction

   task automatic offer(input scan_req_type r, input yield_mode_type mode,
                        input key_event_type typed);
      int gap;
      @(negedge clock);
      req_if.valid       <= 1'b1;
      req_if.kind        <= r.kind;
      req_if.byte_index  <= r.byte_index;
      req_if.column_bits <= r.column_bits;
      req_if.map_index   <= r.map_index;
      req_if.map_keycode <= r.map_keycode;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      track_matrix(r);
      case (mode)
         YIELD_PREDICTED: foreach (fresh_events[i]) pending_events.push_back(fresh_events[i]);
         YIELD_ONE:       pending_events.push_back(typed);
         default:         ;
      endcase
      // bursty sender, with a stretch of back-to-back transfers
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if (!(items_sent >= 150 && items_sent < 250)) gap = $urandom_range(1, 10);
      end else begin
         burst_left--;
      end
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic logic [COL_W-1:0] flip_mask();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return '0;
      if (pick < 9) return COL_W'(1) << $urandom_range(0, COL_W - 1);
      return COL_W'($urandom_range(0, 255));
   endfunction

   initial begin
      scan_req_type r;
      int pick;
      int stop_at;
      int skip;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind = 1'b0;
      req_if.byte_index = '0;
      req_if.column_bits = '0;
      req_if.map_index = '0;
      req_if.map_keycode = '0;
      foreach (prev_cols[i]) prev_cols[i] = '0;
      foreach (keymap[i]) keymap[i] = '0;
      change_seen = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) offer(DIRECTED[i].req, DIRECTED[i].mode, DIRECTED[i].evt);

      while (items_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            r.kind = REQ_MAP;
            r.byte_index = IDX_W'($urandom_range(0, 31));
            r.column_bits = COL_W'($urandom_range(0, 255));
            r.map_index = ($urandom_range(0, 9) == 0) ? MAP_W'($urandom_range(144, 255))
                                                      : MAP_W'($urandom_range(0, 143));
            r.map_keycode = KEY_W'($urandom_range(0, 1023));
            offer(r, YIELD_PREDICTED, NO_EVT);
            if (is_effective(r)) items_sent++;
         end else if (pick < 14) begin
            r.kind = REQ_SAMPLE;
            r.byte_index = IDX_W'($urandom_range(0, 31));
            r.column_bits = COL_W'($urandom_range(0, 255));
            r.map_index = MAP_W'($urandom_range(0, 255));
            r.map_keycode = KEY_W'($urandom_range(0, 1023));
            offer(r, YIELD_PREDICTED, NO_EVT);
            if (is_effective(r)) items_sent++;
         end else begin
            // scan pass, now and then cut short or missing a byte
            stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SCAN_BYTES - 2)
                                                  : SCAN_BYTES - 1;
            skip = ($urandom_range(0, 9) == 0) ? $urandom_range(0, SCAN_BYTES - 1)
                                               : SCAN_BYTES;
            for (int idx = 0; idx <= stop_at; idx++) begin
               if (idx != skip) begin
                  r.kind = REQ_SAMPLE;
                  r.byte_index = IDX_W'(idx);
                  r.column_bits = prev_cols[idx] ^ flip_mask();
                  r.map_index = MAP_W'($urandom_range(0, 255));
                  r.map_keycode = KEY_W'($urandom_range(0, 1023));
                  offer(r, YIELD_PREDICTED, NO_EVT);
                  items_sent++;
               end
            end
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[key_matrix_change_detector] OK");
      end else begin
         $display("[key_matrix_change_detector] ERROR");
      end
      $finish;
   end

   // response side stalls on its own pattern, with one long hold-off
   initial begin
      int cycle;
      int seg_left;
      int mode;
      cycle = 0;
      seg_left = 0;
      mode = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (seg_left == 0) begin
            mode = $urandom_range(0, 3);
            seg_left = $urandom_range(20, 200);
         end
         seg_left--;
         if (cycle >= HOLDOFF_START && cycle < HOLDOFF_START + HOLDOFF_CYCLES) begin
            rsp_if.ready <= 1'b0;
         end else begin
            case (mode)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= 1'($urandom_range(0, 1));
               2:       rsp_if.ready <= (cycle % 4 == 0);
               default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin : check_events
      key_event_type want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_events.size() == 0) begin
            report_mismatch("unexpected transfer, scan_code", 32'(rsp_if.scan_code), '0);
         end else begin
            want = pending_events.pop_front();
            if (rsp_if.event_kind !== want.kind)
               report_mismatch("event_kind", 32'(rsp_if.event_kind), 32'(want.kind));
            if (rsp_if.scan_code !== want.scan_code)
               report_mismatch("scan_code", 32'(rsp_if.scan_code), 32'(want.scan_code));
            if (rsp_if.key_code !== want.key_code)
               report_mismatch("key_code", 32'(rsp_if.key_code), 32'(want.key_code));
            if (rsp_if.pressed !== want.pressed)
               report_mismatch("pressed", 32'(rsp_if.pressed), 32'(want.pressed));
            if (rsp_if.last_of_run !== want.last)
               report_mismatch("last_of_run", 32'(rsp_if.last_of_run), 32'(want.last));
         end
      end
   end

   initial begin
      #2_000_000;
      $display("[key_matrix_change_detector] ERROR");
      $finish;
   end

endmodule
